// File: sv/vsch_pkg.sv
// ----------------------------------------------------------------------------
// vsch_pkg
// Shared types and constants of the trapezoid velocity scheduler.
// ----------------------------------------------------------------------------
package vsch_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_SPEED_LIMIT  = 3'd0,
    REG_ACCEL_LIMIT  = 3'd1,
    REG_SEGMENT_DIST = 3'd2,
    REG_BRAKE_DIST   = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5
  } vsch_reg_t;

  localparam int unsigned IDX_W = 3;

  // reset values
  localparam logic [31:0] SPEED_LIMIT_RST  = 32'd327680;
  localparam logic [31:0] ACCEL_LIMIT_RST  = 32'd6554;
  localparam logic [31:0] SEGMENT_DIST_RST = 32'd16384;
  localparam logic [31:0] BRAKE_DIST_RST   = 32'd8192000;

  // long tick handling: above 0.15 s use 0.1 s
  localparam logic [15:0] DT_LIMIT   = 16'd9830;
  localparam logic [15:0] DT_CLAMPED = 16'd6554;

  // reciprocal of 5 scaled by 2^34, exact for 33-bit dividends
  localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

  // zone codes
  localparam logic [1:0] ZONE_STOP   = 2'd0;
  localparam logic [1:0] ZONE_BRAKE  = 2'd1;
  localparam logic [1:0] ZONE_CRUISE = 2'd2;

  // cycles from an accepted request to its result strobe
  localparam int unsigned LATENCY = 71;

  typedef struct packed {
    logic [31:0] speed_limit;
    logic [31:0] accel_limit;
    logic [31:0] segment_distance;
    logic [31:0] brake_distance;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
  } vsch_cfg_t;

endpackage

// File: sv/vsch_regs.sv
// ----------------------------------------------------------------------------
// vsch_regs
// Configuration register file, written over a valid/ready channel.
// ----------------------------------------------------------------------------
module vsch_regs
  import vsch_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  output vsch_cfg_t        cfg
);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_limit      <= SPEED_LIMIT_RST;
      cfg.accel_limit      <= ACCEL_LIMIT_RST;
      cfg.segment_distance <= SEGMENT_DIST_RST;
      cfg.brake_distance   <= BRAKE_DIST_RST;
      cfg.origin_x         <= '0;
      cfg.origin_y         <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPEED_LIMIT:  cfg.speed_limit      <= cfg_data;
        REG_ACCEL_LIMIT:  cfg.accel_limit      <= cfg_data;
        REG_SEGMENT_DIST: cfg.segment_distance <= cfg_data;
        REG_BRAKE_DIST:   cfg.brake_distance   <= cfg_data;
        REG_ORIGIN_X:     cfg.origin_x         <= cfg_data;
        REG_ORIGIN_Y:     cfg.origin_y         <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/vsch_isqrt.sv
// ----------------------------------------------------------------------------
// vsch_isqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage,
// with a sideband payload carried alongside.
// ----------------------------------------------------------------------------
module vsch_isqrt #(
  parameter int unsigned PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [63:0]   in_rad,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [PW-1:0] out_pay
);

  localparam int unsigned STAGES = 32;

  logic          vld  [0:STAGES];
  logic [63:0]   rad  [0:STAGES];
  logic [31:0]   root [0:STAGES];
  logic [34:0]   rem  [0:STAGES];
  logic [PW-1:0] pay  [0:STAGES];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign pay[0]  = in_pay;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        fits;

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem[i][32:0], rad[i][63:62]};
      trial  = {1'b0, root[i], 2'b01};
      fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      rad[i+1]  <= {rad[i][61:0], 2'b00};
      pay[i+1]  <= pay[i];
      rem[i+1]  <= fits ? (rem_sh - trial) : rem_sh;
      root[i+1] <= {root[i][30:0], fits};
    end
  end

  assign out_valid = vld[STAGES];
  assign out_root  = root[STAGES];
  assign out_pay   = pay[STAGES];

endmodule

// File: sv/trapezoid_velocity_scheduler.sv
// ----------------------------------------------------------------------------
// trapezoid_velocity_scheduler
// Throughput: one request per cycle, busy stays low; the depth comes from
// two 32-stage square root pipelines (distance travelled, braking speed).
// Reset: synchronous, clears all valid bits and restores the registers.
// Each result is shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module trapezoid_velocity_scheduler
  import vsch_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] measured_speed,
  input  logic [15:0]        tick_interval,
  output logic               done,
  output logic signed [31:0] command_speed,
  output logic [31:0]        planned_speed,
  output logic [31:0]        travelled,
  output logic [1:0]         zone,
  output logic               finished,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int unsigned P1_W = 32 + 30 + 33;
  localparam int unsigned P2_W = 32 + 30 + 31 + 32 + 1 + 1;

  vsch_cfg_t cfg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  vsch_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage a: clamp interval, offsets from origin
  logic        a_vld;
  logic [15:0] a_dt;
  logic [32:0] a_ax, a_ay;
  logic [31:0] a_vel;
  logic signed [32:0] dx, dy;

  always_comb begin
    dx = 33'(pos_x) - 33'($signed(cfg.origin_x));
    dy = 33'(pos_y) - 33'($signed(cfg.origin_y));
  end

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= start;
  end

  always_ff @(posedge clk) begin
    a_dt  <= (tick_interval > DT_LIMIT) ? DT_CLAMPED : tick_interval;
    a_ax  <= dx[32] ? 33'(-dx) : 33'(dx);
    a_ay  <= dy[32] ? 33'(-dy) : 33'(dy);
    a_vel <= measured_speed;
  end

  // stage b: squares and accel times interval
  logic        b_vld;
  logic [64:0] b_sx, b_sy;
  logic [45:0] b_adt;
  logic [31:0] b_vel;
  logic [47:0] adt_full;
  logic [65:0] sx_full, sy_full;

  always_comb begin
    adt_full = cfg.accel_limit * a_dt;
    sx_full  = a_ax * a_ax;
    sy_full  = a_ay * a_ay;
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else     b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    b_sx  <= sx_full[64:0];
    b_sy  <= sy_full[64:0];
    b_adt <= adt_full[45:0];
    b_vel <= a_vel;
  end

  // stage c: saturating sum, ramp step prescale
  logic        c_vld;
  logic [63:0] c_sum;
  logic [29:0] c_up;
  logic [32:0] c_y;
  logic [31:0] c_vel;
  logic [65:0] sum_full;
  logic [48:0] adt6;

  always_comb begin
    sum_full = {1'b0, b_sx} + {1'b0, b_sy};
    adt6     = {b_adt, 2'b00} + {1'b0, b_adt, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else     c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    c_sum <= (sum_full[65:64] != 2'b00) ? '1 : sum_full[63:0];
    c_up  <= b_adt[45:16];
    c_y   <= adt6[48:16];
    c_vel <= b_vel;
  end

  // distance travelled
  logic            s1_vld;
  logic [31:0]     s1_root;
  logic [P1_W-1:0] s1_pay;

  vsch_isqrt #(.PW(P1_W)) u_sqrt_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_vld),
    .in_rad    (c_sum),
    .in_pay    ({c_vel, c_up, c_y}),
    .out_valid (s1_vld),
    .out_root  (s1_root),
    .out_pay   (s1_pay)
  );

  // stage d: distance to go, zone decision, down step
  logic        d_vld;
  logic [31:0] d_vel, d_trav, d_togo;
  logic [29:0] d_up;
  logic [30:0] d_dn;
  logic        d_fin, d_brake;
  logic [32:0] togo_full;
  logic [64:0] dn_full;

  always_comb begin
    togo_full = {1'b0, cfg.segment_distance} - {1'b0, s1_root};
    dn_full   = s1_pay[32:0] * RECIP5;
  end

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else     d_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    d_vel   <= s1_pay[P1_W-1 -: 32];
    d_up    <= s1_pay[62:33];
    d_dn    <= dn_full[64:34];
    d_trav  <= s1_root;
    d_togo  <= togo_full[31:0];
    d_fin   <= (cfg.segment_distance <= s1_root);
    d_brake <= (togo_full[31:0] <= cfg.brake_distance);
  end

  // stage e: braking product
  logic        e_vld;
  logic [63:0] e_p;
  logic [P2_W-1:0] e_pay;

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else     e_vld <= d_vld;
  end

  always_ff @(posedge clk) begin
    e_p   <= d_togo * cfg.accel_limit;
    e_pay <= {d_vel, d_up, d_dn, d_trav, d_fin, d_brake};
  end

  // braking speed
  logic            s2_vld;
  logic [31:0]     s2_root;
  logic [P2_W-1:0] s2_pay;
  logic [63:0]     p2;

  assign p2 = e_p[63] ? '1 : {e_p[62:0], 1'b0};

  vsch_isqrt #(.PW(P2_W)) u_sqrt_brake (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_vld),
    .in_rad    (p2),
    .in_pay    (e_pay),
    .out_valid (s2_vld),
    .out_root  (s2_root),
    .out_pay   (s2_pay)
  );

  // stage g: scheduled speed
  logic        g_vld;
  logic [31:0] g_sched, g_vel, g_trav;
  logic [29:0] g_up;
  logic [30:0] g_dn;
  logic [1:0]  g_zone;
  logic        g_fin;
  logic        s2_fin, s2_brake;

  assign s2_fin   = s2_pay[1];
  assign s2_brake = s2_pay[0];

  always_ff @(posedge clk) begin
    if (rst) g_vld <= 1'b0;
    else     g_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    g_vel  <= s2_pay[P2_W-1 -: 32];
    g_up   <= s2_pay[94:65];
    g_dn   <= s2_pay[64:34];
    g_trav <= s2_pay[33:2];
    g_fin  <= s2_fin;
    if (s2_fin) begin
      g_sched <= '0;
      g_zone  <= ZONE_STOP;
    end else if (s2_brake) begin
      g_sched <= s2_root;
      g_zone  <= ZONE_BRAKE;
    end else begin
      g_sched <= cfg.speed_limit;
      g_zone  <= ZONE_CRUISE;
    end
  end

  // stage h: ramp the command toward the scheduled speed
  logic signed [33:0] vel_s, sched_s, t_up, t_dn, cmd;

  always_comb begin
    vel_s   = 34'($signed(g_vel));
    sched_s = {2'b00, g_sched};
    t_up    = vel_s + {4'b0000, g_up};
    t_dn    = vel_s - {3'b000, g_dn};
    if (vel_s < sched_s) begin
      cmd = (t_up < sched_s) ? t_up : sched_s;
    end else if (vel_s > sched_s) begin
      cmd = (t_dn > sched_s) ? t_dn : sched_s;
    end else begin
      cmd = sched_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= g_vld;
  end

  always_ff @(posedge clk) begin
    if (g_fin) begin
      command_speed <= '0;
    end else if (cmd > 34'sh7FFFFFFF) begin
      command_speed <= 32'sh7FFFFFFF;
    end else begin
      command_speed <= cmd[31:0];
    end
    planned_speed <= g_sched;
    travelled     <= g_trav;
    zone          <= g_zone;
    finished      <= g_fin;
  end

endmodule

// File: sv/vsch_checker.sv
// ----------------------------------------------------------------------------
// vsch_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module vsch_checker
  import vsch_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] command_speed,
  input logic [31:0]        planned_speed,
  input logic [1:0]         zone,
  input logic               finished
);

  // every request yields its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("missing result after request");

  // a finished segment commands and plans zero in the stop zone
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (done && finished) |-> (command_speed == 0 && planned_speed == 0 && zone == ZONE_STOP))
    else $error("finished result not zeroed");

  // an unfinished segment is braking or cruising
  a_zone: assert property (@(posedge clk) disable iff (rst)
    (done && !finished) |-> (zone == ZONE_BRAKE || zone == ZONE_CRUISE))
    else $error("bad zone for unfinished segment");

  // no result strobe without an earlier request
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

endmodule

bind trapezoid_velocity_scheduler vsch_checker u_vsch_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .command_speed (command_speed),
  .planned_speed (planned_speed),
  .zone          (zone),
  .finished      (finished)
);
